// ----- src/positional_list_engine_top_macros.svh -----
// ---------------------------------------------------------------------------
// positional list engine assertion macros
// shared concurrent assertion forms for the list engine rtl
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PLLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PLLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/plle_pkg.sv -----
// ---------------------------------------------------------------------------
// plle_pkg
// types and constants shared by the positional list engine
// ---------------------------------------------------------------------------
package plle_pkg;

	localparam int DATA_W   = 32;
	localparam int CMD_W    = 3;
	localparam int POS_W    = 7;
	localparam int STAT_W   = 2;
	localparam int CNT_W    = 7;
	localparam int GRP_SIZE = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ     = 3'd0,
		CMD_INS_HEAD = 3'd1,
		CMD_INS_TAIL = 3'd2,
		CMD_INS_POS  = 3'd3,
		CMD_DELETE   = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} stat_t;

	// shift request seen by every cell of the chain
	typedef struct packed {
		logic ins;
		logic del;
	} shift_ctl_t;

endpackage

// ----- src/plle_cell.sv -----
// ---------------------------------------------------------------------------
// plle_cell
// one list slot: holds, takes the new value, or shifts from a neighbour
// ---------------------------------------------------------------------------
module plle_cell
	import plle_pkg::*;
#(
	parameter int IDX = 0,
	parameter int PW  = 7
) (
	input  logic              clk,
	input  shift_ctl_t        ctl,
	input  logic [PW-1:0]     pos,
	input  logic [DATA_W-1:0] ins_value,
	input  logic [DATA_W-1:0] prev_value,
	input  logic [DATA_W-1:0] next_value,
	output logic [DATA_W-1:0] value
);

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_IDX > pos) begin
				value_q <= prev_value;
			end else if (MY_IDX == pos) begin
				value_q <= ins_value;
			end
		end else if (ctl.del) begin
			if (MY_IDX >= pos) begin
				value_q <= next_value;
			end
		end
	end

	assign value = value_q;

endmodule

// ----- src/plle_rgrp.sv -----
// ---------------------------------------------------------------------------
// plle_rgrp
// registered read selection over one group of neighbouring cells
// ---------------------------------------------------------------------------
module plle_rgrp
	import plle_pkg::*;
#(
	parameter int BASE = 0,
	parameter int N    = 8,
	parameter int PW   = 7
) (
	input  logic              clk,
	input  logic              cap,
	input  logic [PW-1:0]     pos,
	input  logic [DATA_W-1:0] vals [N],
	output logic [DATA_W-1:0] grp
);

	logic [DATA_W-1:0] hit_or;
	logic [DATA_W-1:0] grp_q;

	// at most one cell matches, so an or of masked values selects it
	always_comb begin
		hit_or = '0;
		for (int j = 0; j < N; j++) begin
			if (PW'(BASE + j) == pos) begin
				hit_or = hit_or | vals[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			grp_q <= hit_or;
		end
	end

	assign grp = grp_q;

endmodule

// ----- src/positional_list_engine_top.sv -----
// ---------------------------------------------------------------------------
// positional_list_engine_top
// throughput: one request per cycle while results are taken, the whole cell chain shifts on the same clock edge
// the read path is a registered group select followed by the output register
// reset: arst_n clears the count and all valid flags, cell contents undefined
// ---------------------------------------------------------------------------
`include "positional_list_engine_top_macros.svh"

module positional_list_engine_top
	import plle_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // position[6:0], item_value[38:7], zero pad
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // read_value[31:0], status[33:32],
	                              // element_count[40:34], zero pad
);

	// count needs to hold the capacity itself
	localparam int CW = $clog2(CAPACITY + 1);
	// compare width wide enough for both position and count
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	// number of read groups in the first level of the read tree
	localparam int NG = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	// request fields
	cmd_t              req_cmd;
	logic [POS_W-1:0]  req_pos;
	logic [DATA_W-1:0] req_value;

	assign req_cmd   = cmd_t'(s_tuser[2:0]);
	assign req_pos   = s_tdata[6:0];
	assign req_value = s_tdata[38:7];

	// list state
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_nxt;
	logic [DATA_W-1:0] cell_val [CAPACITY];
	logic [DATA_W-1:0] grp_val  [NG];

	// decode of the request against the current count
	logic          in_acc;
	logic          ins_ok;
	logic          del_ok;
	logic          rd_ok;
	logic          rd_fail;
	stat_t         req_st;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	logic [PW-1:0] sel_pos;
	logic          full;
	shift_ctl_t    ctl;

	// first stage and output register
	logic              vld_s1;
	logic              rd_ok_s1;
	logic              rd_fail_s1;
	stat_t             st_s1;
	logic [CNT_W-1:0]  cnt_s1;
	logic              out_vld_q;
	logic [47:0]       out_data_q;
	logic              advance;
	logic [DATA_W-1:0] grp_or;
	logic [DATA_W-1:0] rd_val;
	logic [PW-1:0]     cnt_nxt_ext;

	assign pos_w = PW'(req_pos);
	assign cnt_w = PW'(count_q);
	assign full  = (count_q == CW'(CAPACITY));

	always_comb begin
		ins_ok  = 1'b0;
		del_ok  = 1'b0;
		rd_ok   = 1'b0;
		rd_fail = 1'b0;
		req_st  = ST_DONE;
		sel_pos = pos_w;
		unique case (req_cmd)
			CMD_READ: begin
				if (pos_w >= cnt_w) begin
					rd_fail = 1'b1;
					req_st  = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			CMD_INS_HEAD: begin
				sel_pos = '0;
				if (full) begin
					req_st = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			CMD_INS_TAIL: begin
				sel_pos = cnt_w;
				if (full) begin
					req_st = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			CMD_INS_POS: begin
				// range is checked before fullness
				if (pos_w > cnt_w) begin
					req_st = ST_RANGE;
				end else if (full) begin
					req_st = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			CMD_DELETE: begin
				if (pos_w >= cnt_w) begin
					req_st = ST_RANGE;
				end else begin
					del_ok = 1'b1;
				end
			end
			default: begin
				// undefined commands leave the list alone and report done
			end
		endcase
	end

	// handshake: the first stage moves on whenever the output slot frees up
	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;
	assign in_acc   = s_tvalid && s_tready;

	assign ctl.ins = in_acc && ins_ok;
	assign ctl.del = in_acc && del_ok;

	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + 1'b1;
		end else if (ctl.del) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// element count is reported modulo 128
	assign cnt_nxt_ext = PW'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// chain of cells, each shifting from its neighbour on insert or delete
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] prev_v;
		logic [DATA_W-1:0] next_v;

		if (i == 0) begin : g_head
			assign prev_v = req_value;
		end else begin : g_mid_prev
			assign prev_v = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_v = cell_val[i];
		end else begin : g_mid_next
			assign next_v = cell_val[i+1];
		end

		plle_cell #(
			.IDX (i),
			.PW  (PW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.pos        (sel_pos),
			.ins_value  (req_value),
			.prev_value (prev_v),
			.next_value (next_v),
			.value      (cell_val[i])
		);
	end

	// read tree, first level: one registered select per group of cells
	for (genvar g = 0; g < NG; g++) begin : g_grp
		localparam int GB = g * GRP_SIZE;
		localparam int GN = (CAPACITY - GB < GRP_SIZE) ? (CAPACITY - GB) : GRP_SIZE;

		logic [DATA_W-1:0] gv [GN];

		for (genvar j = 0; j < GN; j++) begin : g_tap
			assign gv[j] = cell_val[GB + j];
		end

		plle_rgrp #(
			.BASE (GB),
			.N    (GN),
			.PW   (PW)
		) u_rgrp (
			.clk  (clk),
			.cap  (in_acc),
			.pos  (pos_w),
			.vals (gv),
			.grp  (grp_val[g])
		);
	end

	// read tree, second level: only the matching group can be non-zero
	always_comb begin
		grp_or = '0;
		for (int g = 0; g < NG; g++) begin
			grp_or = grp_or | grp_val[g];
		end
	end

	// first stage: status and count travel beside the group registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_ok_s1   <= rd_ok;
			rd_fail_s1 <= rd_fail;
			st_s1      <= req_st;
			cnt_s1     <= cnt_nxt_ext[CNT_W-1:0];
		end
	end

	// failed read gives all ones, non-read commands give zero
	always_comb begin
		if (rd_ok_s1) begin
			rd_val = grp_or;
		end else if (rd_fail_s1) begin
			rd_val = '1;
		end else begin
			rd_val = '0;
		end
	end

	// output register parts the result side from the request side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {7'd0, cnt_s1, st_s1, rd_val};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// count never runs past the capacity
	`PLLE_ASSERT_IMP(a_cnt_cap, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")

	// an accepted insert grows the list by exactly one
	`PLLE_ASSERT_NXT(a_ins_inc, clk, arst_n, ctl.ins, count_q == CW'($past(count_q) + 1'b1), "insert count step")

	// a pending result that cannot leave blocks new requests
	`PLLE_ASSERT_IMP(a_stall_blk, clk, arst_n, vld_s1 && out_vld_q && !m_tready, !s_tready, "accepted while blocked")

	// a list full status is only reported while the list is at capacity
	`PLLE_ASSERT_IMP(a_full_cnt, clk, arst_n, vld_s1 && (st_s1 == ST_FULL), full, "full status with room left")

endmodule

// ----- dv/positional_list_engine_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_list_engine_checker
// watches both streams of the list engine, keeps its own copy of the list,
// works out the answer to every accepted request and compares each result
// field by field, oldest first
// ---------------------------------------------------------------------------
module positional_list_engine_checker
	import plle_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	output int          fail_count,
	output int          outstanding,
	output int          list_len
);

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		stat_t             status;
		logic [CNT_W-1:0]  element_count;
	} list_answer_t;

	logic [DATA_W-1:0] cells [CAPACITY];
	int unsigned       stored;
	list_answer_t      answers_q [$];

	initial fail_count = 0;

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		fail_count++;
		$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
	endtask

	// range check comes before the full check
	function automatic stat_t insert_at(int unsigned at, logic [DATA_W-1:0] v);
		if (at > stored)
			return ST_RANGE;
		if (stored >= CAPACITY)
			return ST_FULL;
		for (int unsigned i = stored; i > at; i--)
			cells[i] = cells[i - 1];
		cells[at] = v;
		stored++;
		return ST_DONE;
	endfunction

	function automatic list_answer_t apply_request(logic [CMD_W-1:0] code,
			logic [POS_W-1:0] at, logic [DATA_W-1:0] v);
		list_answer_t ans;
		ans.read_value = '0;
		ans.status     = ST_DONE;
		case (code)
			CMD_READ: begin
				if (at < stored) begin
					ans.read_value = cells[at];
				end else begin
					ans.read_value = '1;
					ans.status     = ST_RANGE;
				end
			end
			CMD_INS_HEAD: ans.status = insert_at(0, v);
			CMD_INS_TAIL: ans.status = insert_at(stored, v);
			CMD_INS_POS:  ans.status = insert_at(at, v);
			CMD_DELETE: begin
				if (at < stored) begin
					for (int unsigned i = at; i + 1 < stored; i++)
						cells[i] = cells[i + 1];
					stored--;
				end else begin
					ans.status = ST_RANGE;
				end
			end
			default: ;  // undefined codes leave the list alone
		endcase
		ans.element_count = stored[CNT_W-1:0];
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_answer_t want;
		if (!arst_n) begin
			stored = 0;
			answers_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (answers_q.size() == 0) begin
					report_mismatch("unrequested result", m_tdata[31:0], '0);
				end else begin
					want = answers_q.pop_front();
					if (m_tdata[31:0] !== want.read_value)
						report_mismatch("read_value", m_tdata[31:0], want.read_value);
					if (m_tdata[33:32] !== want.status)
						report_mismatch("status", m_tdata[33:32], want.status);
					if (m_tdata[40:34] !== want.element_count)
						report_mismatch("element_count", m_tdata[40:34], want.element_count);
				end
			end
			if (s_tvalid && s_tready)
				answers_q.push_back(apply_request(s_tuser, s_tdata[POS_W-1:0],
					s_tdata[POS_W+DATA_W-1:POS_W]));
		end
		outstanding = answers_q.size();
		list_len    = stored;
	end

endmodule

// ----- dv/tb_positional_list_engine_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_positional_list_engine_top
// drives command requests into the list engine with random gaps and random
// result back-pressure; a directed opening is followed by phases that grow
// the list to full, drain it to empty and wander in between, while the
// checker beside the block predicts and compares every result
// ---------------------------------------------------------------------------
module tb_positional_list_engine_top;
	import plle_pkg::*;

	localparam int CAPACITY       = 64;
	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 12;
	localparam int TOTAL_REQUESTS = 1950;
	localparam int MAX_IDLE       = 17;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 8;
	localparam int LIMIT_CYCLES   = 600000;
	localparam int POS_MAX        = (1 << POS_W) - 1;
	// command codes with no meaning, the engine must ignore them
	localparam int UNDEF_LO       = int'(CMD_DELETE) + 1;
	localparam int UNDEF_HI       = (1 << CMD_W) - 1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // position[6:0], item_value[38:7], zero pad
	logic [2:0]  s_tuser;   // cmd[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // read_value[31:0], status[33:32], element_count[40:34]

	int   fail_count;
	int   outstanding;
	int   list_len;
	logic req_taken = 1'b0;
	logic res_taken = 1'b0;
	bit   hold_ask  = 1'b0;    // asks the receiver for one long hold-off
	bit   send_calm = 1'b0;    // sender offers back to back while set
	int   sent      = 0;

	always #(HALF_PERIOD) clk = ~clk;

	positional_list_engine_top #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	positional_list_engine_checker #(
		.CAPACITY(CAPACITY)
	) list_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.outstanding(outstanding),
		.list_len   (list_len)
	);

	// handshakes seen at the rising edge, looked at on the following falling edge
	always @(posedge clk) begin
		req_taken <= s_tvalid && s_tready;
		res_taken <= m_tvalid && m_tready;
	end

	// mostly random 32-bit values, now and then the extremes
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '1;
			3:       return '0;
			default: return $urandom();
		endcase
	endfunction

	// a position below limit most of the time, its edges often, any 7-bit value now and then
	function automatic logic [POS_W-1:0] pick_pos(int limit, logic [POS_W-1:0] wild);
		int r;
		r = $urandom_range(0, 9);
		if (limit == 0 || r == 0)
			return wild;
		if (r == 1)
			return limit - 1;
		if (r == 2)
			return limit;
		return $urandom_range(0, limit - 1);
	endfunction

	// one request: optional idle gap, then hold it up until the engine takes it
	task automatic send_request(input logic [CMD_W-1:0] code, input logic [POS_W-1:0] at,
			input logic [DATA_W-1:0] v);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= code;
		s_tdata  <= {1'b0, v, at};
		do @(negedge clk); while (!req_taken);
		sent++;
	endtask

	// stop offering until every answer is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// weights in percent for inserts and deletes, a few undefined codes, reads for the rest
	task automatic random_request(input int ins_w, input int del_w);
		int               r;
		logic [CMD_W-1:0] code;
		logic [POS_W-1:0] at;
		r  = $urandom_range(0, 99);
		at = $urandom_range(0, POS_MAX);
		if (r < 4) begin
			code = $urandom_range(UNDEF_LO, UNDEF_HI);
		end else if (r < 4 + ins_w) begin
			case ($urandom_range(0, 2))
				0:       code = CMD_INS_HEAD;
				1:       code = CMD_INS_TAIL;
				default: code = CMD_INS_POS;
			endcase
			at = pick_pos(list_len + 1, at);
		end else if (r < 4 + ins_w + del_w) begin
			code = CMD_DELETE;
			at   = pick_pos(list_len, at);
		end else begin
			code = CMD_READ;
			at   = pick_pos(list_len, at);
		end
		send_request(code, at, pick_value());
	endtask

	// result side: random stall per result, calm stretches, one long hold-off on request
	initial begin
		int stall;
		int results;
		bit calm;
		m_tready = 1'b0;
		results  = 0;
		calm     = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_ask) begin
				// long back-pressure so the engine fills up and refuses requests
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_ask = 1'b0;
			end
			if (results % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!res_taken);
			results++;
		end
	end

	// request side and verdict
	initial begin
		int phase;
		int n;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		phase    = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list: failed read, failed delete, insert beyond the count
		send_request(CMD_READ, 0, $urandom());
		send_request(CMD_DELETE, 0, $urandom());
		send_request(CMD_INS_POS, 1, 32'h1234_5678);
		// insert at the count appends, then each insert kind with extreme values
		send_request(CMD_INS_POS, 0, 32'h7FFF_FFFF);
		send_request(CMD_INS_HEAD, 0, 32'h8000_0000);
		send_request(CMD_INS_TAIL, POS_MAX, 32'hFFFF_FFFF);
		send_request(CMD_INS_POS, 3, 32'h0000_0000);
		send_request(CMD_INS_POS, 2, 32'hA5A5_5A5A);
		// reads at both ends, just past the end and at the largest position
		send_request(CMD_READ, 0, $urandom());
		send_request(CMD_READ, 4, $urandom());
		send_request(CMD_READ, 5, $urandom());
		send_request(CMD_READ, POS_MAX, $urandom());
		// insert past the count and at the largest position are refused
		send_request(CMD_INS_POS, 6, $urandom());
		send_request(CMD_INS_POS, POS_MAX, $urandom());
		// deletes at the tail and head, then out of range ones
		send_request(CMD_DELETE, 4, $urandom());
		send_request(CMD_DELETE, 0, $urandom());
		send_request(CMD_DELETE, POS_MAX, $urandom());
		send_request(CMD_DELETE, 3, $urandom());
		// undefined codes
		send_request(3'(UNDEF_LO), POS_MAX, $urandom());
		send_request(3'(UNDEF_LO + 1), 0, $urandom());
		send_request(3'(UNDEF_HI), POS_MAX, '1);
		// middle delete shifts the tail up
		send_request(CMD_READ, 1, $urandom());
		send_request(CMD_DELETE, 1, $urandom());
		send_request(CMD_READ, 1, $urandom());
		wait_drained();

		while (sent < TOTAL_REQUESTS) begin
			send_calm = ($urandom_range(0, 3) == 0);
			case (phase % 3)
				0: begin
					// grow until full, the first time with the receiver holding off
					n = 0;
					while (n < 400 && list_len < CAPACITY) begin
						if (phase == 0 && n == 16)
							hold_ask = 1'b1;
						random_request(55, 20);
						n++;
					end
					// full list: every insert kind is refused, reads at the last slots
					repeat (12) begin
						case ($urandom_range(0, 3))
							0: send_request(CMD_INS_HEAD, $urandom_range(0, POS_MAX), pick_value());
							1: send_request(CMD_INS_TAIL, $urandom_range(0, POS_MAX), pick_value());
							2: send_request(CMD_INS_POS,
								$urandom_range(CAPACITY - 1, CAPACITY + 1), pick_value());
							default: send_request(CMD_READ,
								$urandom_range(CAPACITY - 2, CAPACITY), $urandom());
						endcase
					end
				end
				1: begin
					// drain to empty, then poke the empty list
					n = 0;
					while (n < 400 && list_len > 0) begin
						random_request(20, 55);
						n++;
					end
					repeat (8) random_request(30, 30);
				end
				default: begin
					// wander around the middle
					repeat (150) random_request(35, 35);
				end
			endcase
			if ($urandom_range(0, 1) == 0)
				wait_drained();
			phase++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// hard stop for a hung handshake or a missing result
	initial begin
		#(2 * HALF_PERIOD * LIMIT_CYCLES);
		$display("status: fail");
		$finish;
	end

endmodule
